/* design/itda_pkg.sv */
package itda_pkg;

  // ascii codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;

  // a 32-bit magnitude has at most ten decimal digits
  localparam int MaxDigits = 10;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int IdxW      = $clog2(MaxDigits);
  localparam int DigW      = 4;

  // divide by ten: floor(n * Recip / 2^RecipShift) for any 32-bit n
  localparam logic [31:0] Recip      = 32'hCCCCCCCD;
  localparam int          RecipShift = 35;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [DigW-1:0] dig_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new request
    logic div_step;    // peel one digit off the magnitude
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top stacked digit into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;         // value was negative
    logic div_last;    // this divide step yields the last digit
    logic digit_last;  // one digit left on the stack
  } sts_t;

endpackage

/* design/itda_dpath.sv */
module itda_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         in_value,
  input  itda_pkg::cmd_t      cmd,
  output itda_pkg::sts_t      sts,
  output logic [7:0]          out_char_code,
  output logic                out_is_last
);

  logic [31:0]             mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  itda_pkg::cnt_t          cnt_r, cnt_nxt;
  itda_pkg::dig_t          dig_r [itda_pkg::MaxDigits];
  logic [7:0]              char_r, char_nxt;
  logic                    last_r, last_nxt;

  logic [63:0]             prod;
  logic [31:0]             quot;
  logic [31:0]             quot10;
  itda_pkg::dig_t          rem;
  logic [itda_pkg::IdxW-1:0] wr_idx;
  logic [itda_pkg::IdxW-1:0] rd_idx;
  itda_pkg::cnt_t          cnt_dec;

  // reciprocal multiply gives the quotient, remainder from the low bits
  assign prod   = {32'b0, mag_r} * {32'b0, itda_pkg::Recip};
  assign quot   = {3'b000, prod[63:itda_pkg::RecipShift]};
  assign quot10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
  assign rem    = itda_pkg::dig_t'(mag_r[3:0] - quot10[3:0]);

  assign cnt_dec = cnt_r - itda_pkg::cnt_t'(1);
  assign wr_idx  = cnt_r[itda_pkg::IdxW-1:0];
  assign rd_idx  = cnt_dec[itda_pkg::IdxW-1:0];

  // status back to the controller
  assign sts.neg        = neg_r;
  assign sts.div_last   = (quot == 32'd0) ||
                          (cnt_r == itda_pkg::cnt_t'(itda_pkg::MaxDigits - 1));
  assign sts.digit_last = (cnt_r == itda_pkg::cnt_t'(1));

  // magnitude, sign and digit count
  always_comb begin
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      neg_nxt = in_value[31];
      mag_nxt = in_value[31] ? (32'd0 - in_value) : in_value;
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      mag_nxt = quot;
      cnt_nxt = cnt_r + itda_pkg::cnt_t'(1);
    end else if (cmd.emit_digit) begin
      cnt_nxt = cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
  end

  // digit stack, least significant digit pushed first
  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      dig_r[wr_idx] <= rem;
    end
  end

  // output register
  always_comb begin
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.emit_sign) begin
      char_nxt = itda_pkg::CharMinus;
      last_nxt = 1'b0;
    end else if (cmd.emit_digit) begin
      char_nxt = itda_pkg::CharZero + {4'b0000, dig_r[rd_idx]};
      last_nxt = sts.digit_last;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_char_code = char_r;
  assign out_is_last   = last_r;

`ifndef SYNTHESIS
  // stack never overflows
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= itda_pkg::cnt_t'(itda_pkg::MaxDigits))
    else $error("digit count out of range");

  // every digit pushed is a decimal digit
  a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem < itda_pkg::dig_t'(10))
    else $error("remainder is not a decimal digit");
`endif

endmodule

/* design/itda_ctrl.sv */
module itda_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  itda_pkg::sts_t sts,
  output itda_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       oval_r, oval_nxt;
  logic       out_free;

  // output register can take a new character
  assign out_free = !oval_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // sequencing
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = sts.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.digit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    oval_nxt = oval_r;
    if (cmd.emit_sign || cmd.emit_digit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;

`ifndef SYNTHESIS
  // an accepted request always starts with a divide step
  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DIV)
    else $error("request not followed by divide");

  // nothing is emitted while digits are still being produced
  a_no_emit_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> !cmd.emit_sign && !cmd.emit_digit)
    else $error("emit during divide");

  // last digit returns the controller to idle with a character pending
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.digit_last) |=> state_r == S_IDLE && oval_r)
    else $error("last digit did not end the request");
`endif

endmodule

/* design/int_to_decimal_ascii.sv */
// channel | ports                      | direction | contents
// in      | in_valid, in_ready         | input     | in_value: signed 32-bit integer
// out     | out_valid, out_ready       | output    | out_char_code, out_is_last
//
// a request is accepted in idle, then the magnitude is divided by ten once per digit,
// then a '-' (if negative) and the digits are emitted, most significant first.
// the digit stack is filled least significant first, so emission waits for it.
// rst_n is synchronous, active low; it clears the controller, output valid and the digit count.
// a stall on out_ready holds the current character and pauses emission.
module int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_code,
  output logic        out_is_last
);

  itda_pkg::cmd_t cmd;
  itda_pkg::sts_t sts;

  // sequencer
  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // divide and digit stack
  itda_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400_000;
  localparam int DrainCycles = 30;
  localparam int MaxErrLines = 40;

  // receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // one expected character
  typedef struct {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char_code;
  logic        out_is_last;

  ascii_char_t pending_chars[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          rx_phase = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  int          burst_left = 1;
  int          burst_max = 1;
  int          gap_max = 0;

  int_to_decimal_ascii i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_is_last  (out_is_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // count a mismatch, print a bounded number of lines
  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxErrLines) begin
      $display("ERROR @%0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // expected characters of one request, most significant first
  function automatic void predict_chars(input logic [31:0] value);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  digs [itda_pkg::MaxDigits];
    int          nd;
    neg = value[31];
    mag = neg ? (32'd0 - value) : value;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      nd++;
    end while (mag != 32'd0 && nd < itda_pkg::MaxDigits);
    if (neg) begin
      pending_chars.push_back(ascii_char_t'{itda_pkg::CharMinus, 1'b0});
    end
    for (int k = nd - 1; k >= 0; k--) begin
      pending_chars.push_back(ascii_char_t'{itda_pkg::CharZero + 8'(digs[k]), (k == 0)});
    end
  endfunction

  // random value with a chosen number of decimal digits and a random sign
  function automatic logic [31:0] rand_with_digits(input int nd);
    longint lo;
    longint hi;
    longint mag;
    logic   neg;
    lo = 1;
    for (int k = 1; k < nd; k++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (nd == 1) begin
      lo = 0;
    end
    neg = 1'($urandom);
    if (hi > 64'sd2147483647) begin
      hi = neg ? 64'sd2147483648 : 64'sd2147483647;
    end
    mag = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  // send one request, record its characters on accept, then maybe idle
  task automatic send_value(input logic [31:0] value);
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_chars(value);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, burst_max);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // wait for every expected character, then a little longer
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // receiver stall pattern and result check
  always @(posedge clk) begin
    ascii_char_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", out_char_code, out_is_last));
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char_code !== exp_c.code) begin
          report_mismatch($sformatf("char_code got %h want %h", out_char_code, exp_c.code));
        end
        if (out_is_last !== exp_c.last) begin
          report_mismatch($sformatf("is_last got %b want %b", out_is_last, exp_c.last));
        end
      end
    end
    rx_phase <= (rx_phase == 6) ? 0 : rx_phase + 1;
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= (rx_phase >= 3);
      default:     out_ready <= 1'b1;
    endcase
  end

  // extremes, digit-count boundaries and the special cases
  task automatic test_directed();
    logic [31:0] vals [$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             -32'sd100, 32'd12345, 32'd999999999, 32'd1000000000, -32'sd999999999,
             -32'sd1000000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
             32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF, 32'hFFFF0000,
             32'd7, -32'sd9};
    rx_mode = RX_ALWAYS;
    gap_max = 0;
    burst_max = 1;
    foreach (vals[i]) begin
      send_value(vals[i]);
    end
    wait_idle();
  endtask

  // every digit count, both signs, bursts with a light stall
  task automatic test_digit_lengths();
    rx_mode = RX_LIGHT;
    gap_max = 6;
    burst_max = 8;
    repeat (180) begin
      send_value(rand_with_digits($urandom_range(1, 10)));
    end
    wait_idle();
  endtask

  // full 32-bit random values under a heavy stall
  task automatic test_full_range();
    rx_mode = RX_HEAVY;
    gap_max = 12;
    burst_max = 4;
    repeat (160) begin
      send_value($urandom);
    end
    wait_idle();
  endtask

  // back to back requests against a periodic stall
  task automatic test_back_to_back();
    rx_mode = RX_PERIODIC;
    gap_max = 0;
    burst_max = 1;
    repeat (70) begin
      if ($urandom_range(0, 1) == 0) begin
        send_value($urandom);
      end else begin
        send_value(rand_with_digits($urandom_range(1, 10)));
      end
    end
    wait_idle();
  endtask

  // mixed pacing with an unstalled receiver
  task automatic test_no_stall();
    rx_mode = RX_ALWAYS;
    gap_max = 3;
    burst_max = 5;
    repeat (70) begin
      send_value(rand_with_digits($urandom_range(1, 10)));
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_digit_lengths();
    test_full_range();
    test_back_to_back();
    test_no_stall();
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
